// ----- design/dfpa_pkg.sv -----
// shared types, constants and the power-of-ten table for the decimal fixed-point alu
package dfpa_pkg;

  localparam int OPND_BITS      = 64;
  localparam int HALF_BITS      = OPND_BITS / 2;
  localparam int DIV_BITS       = 2 * OPND_BITS;
  localparam int SCALE_BITS     = 5;
  localparam int DEF_MAX_SCALE  = 18;
  localparam int DEF_VALUE_BITS = 64;

  typedef enum logic [1:0] {
    MODE_ADD = 2'd0,
    MODE_SUB = 2'd1,
    MODE_MUL = 2'd2,
    MODE_DIV = 2'd3
  } dfpa_mode_e;

  typedef struct packed {
    logic [1:0]                  mode;
    logic signed [OPND_BITS-1:0] left_value;
    logic [SCALE_BITS-1:0]       left_scale;
    logic signed [OPND_BITS-1:0] right_value;
    logic [SCALE_BITS-1:0]       right_scale;
  } dfpa_in_t;

  typedef struct packed {
    logic signed [OPND_BITS-1:0] result_value;
    logic [SCALE_BITS-1:0]       result_scale;
    logic                        divide_by_zero;
    logic                        overflow;
  } dfpa_out_t;

  // operand details that ride alongside the divider cells
  typedef struct packed {
    dfpa_mode_e            mode;
    logic                  x_neg;
    logic                  y_neg;
    logic [OPND_BITS-1:0]  x_raw;
    logic [SCALE_BITS-1:0] scale;
    logic [DIV_BITS-1:0]   num2;
    logic                  dbz;
  } dfpa_side_t;

  // one restoring-division step: partial remainder, numerator shifting into quotient
  typedef struct packed {
    logic [DIV_BITS-1:0] rem;
    logic [DIV_BITS-1:0] nq;
    logic [DIV_BITS-1:0] d;
    dfpa_side_t          side;
  } dfpa_div_t;

  function automatic logic [OPND_BITS-1:0] pow10(input logic [SCALE_BITS-1:0] k);
    logic [OPND_BITS-1:0] p;
    unique case (k)
      5'd0:    p = 64'd1;
      5'd1:    p = 64'd10;
      5'd2:    p = 64'd100;
      5'd3:    p = 64'd1000;
      5'd4:    p = 64'd10000;
      5'd5:    p = 64'd100000;
      5'd6:    p = 64'd1000000;
      5'd7:    p = 64'd10000000;
      5'd8:    p = 64'd100000000;
      5'd9:    p = 64'd1000000000;
      5'd10:   p = 64'd10000000000;
      5'd11:   p = 64'd100000000000;
      5'd12:   p = 64'd1000000000000;
      5'd13:   p = 64'd10000000000000;
      5'd14:   p = 64'd100000000000000;
      5'd15:   p = 64'd1000000000000000;
      5'd16:   p = 64'd10000000000000000;
      5'd17:   p = 64'd100000000000000000;
      5'd18:   p = 64'd1000000000000000000;
      default: p = 64'd1;
    endcase
    return p;
  endfunction

endpackage

// ----- design/dfpa_div_cell.sv -----
// one restoring-division cell: a single quotient bit per cycle, registered
module dfpa_div_cell
  import dfpa_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  input  dfpa_div_t op_i,
  output logic      valid_o,
  output dfpa_div_t op_o
);

  logic [DIV_BITS:0] trial;
  logic              fits;
  dfpa_div_t         op_d;
  logic              valid_q;
  dfpa_div_t         op_q;

  always_comb begin
    trial = {op_i.rem, op_i.nq[DIV_BITS-1]};
    fits  = trial >= {1'b0, op_i.d};
    op_d  = op_i;
    op_d.rem = fits ? DIV_BITS'(trial - {1'b0, op_i.d}) : trial[DIV_BITS-1:0];
    op_d.nq  = {op_i.nq[DIV_BITS-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
  end

  assign valid_o = valid_q;
  assign op_o    = op_q;

endmodule

// ----- design/dfpa_div_chain.sv -----
// row of division cells, one quotient bit per cell, one word entering each cycle
module dfpa_div_chain
  import dfpa_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  input  dfpa_div_t op_i,
  output logic      valid_o,
  output dfpa_div_t op_o
);

  logic      valid_w [0:DIV_BITS];
  dfpa_div_t op_w    [0:DIV_BITS];

  assign valid_w[0] = valid_i;
  assign op_w[0]    = op_i;

  for (genvar i = 0; i < DIV_BITS; i++) begin : g_cell
    dfpa_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_w[i]),
      .op_i    (op_w[i]),
      .valid_o (valid_w[i+1]),
      .op_o    (op_w[i+1])
    );
  end

  assign valid_o = valid_w[DIV_BITS];
  assign op_o    = op_w[DIV_BITS];

endmodule

// ----- design/decimal_fixed_point_alu.sv -----
// decimal fixed-point alu: add, subtract, multiply and divide at the left operand's scale
//
// usage: drive item_i and raise start_i; the word is taken at any edge where start_i is
// high and busy_o is low. busy_o is never raised, so a new word may be taken every cycle.
// the result appears on result_o for exactly one cycle with done_o high, in the order
// words were taken. the receiver cannot stall the block.
// the pipeline holds a register to take operand magnitudes and powers of ten, registers
// for the split 64x64 multiplies (partial products, then their sums), 128 cells for the
// division by the right scale's power of ten, a register to set up the second division,
// 128 cells for that division (a pass-through outside divide mode), a register for the
// signed add and the output register. throughput is one word per cycle.
// scales above MAX_SCALE saturate. a zero rescaled divisor gives 0 and divide_by_zero;
// a result outside VALUE_BITS signed bits wraps and raises overflow.
// reset clears the valid bits along the pipeline, so words in flight are dropped.
module decimal_fixed_point_alu
  import dfpa_pkg::*;
#(
  parameter int MAX_SCALE  = DEF_MAX_SCALE,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  dfpa_in_t  item_i,
  output logic      busy_o,
  output logic      done_o,
  output dfpa_out_t result_o
);

  // operand stage
  logic                  s0_valid_q;
  dfpa_mode_e            s0_mode_q;
  logic                  s0_xneg_q, s0_yneg_q;
  logic [OPND_BITS-1:0]  s0_xraw_q, s0_xmag_q, s0_ymag_q, s0_pxs_q, s0_pys_q;
  logic [SCALE_BITS-1:0] s0_xs_q;
  logic [SCALE_BITS-1:0] xs_d, ys_d;

  // partial products
  logic                  s1_valid_q;
  dfpa_mode_e            s1_mode_q;
  logic                  s1_xneg_q, s1_yneg_q;
  logic [OPND_BITS-1:0]  s1_xraw_q, s1_pys_q;
  logic [SCALE_BITS-1:0] s1_xs_q;
  logic [OPND_BITS-1:0]  pa_q [0:3];
  logic [OPND_BITS-1:0]  pb_q [0:3];
  logic [OPND_BITS-1:0]  a1, b1;

  // summed products, feeding the first divider
  logic                  s2_valid_q;
  dfpa_div_t             s2_op_q;
  logic [DIV_BITS-1:0]   p1_d, p2_d;

  logic                  d1_valid;
  dfpa_div_t             d1_op;
  logic                  m_valid_q;
  dfpa_div_t             m_op_d;
  dfpa_div_t             m_op_q;
  logic                  q1_zero;

  logic                  d2_valid;
  dfpa_div_t             d2_op;

  logic                  f_valid_q;
  logic [DIV_BITS-1:0]   f_t_q;
  logic [DIV_BITS-1:0]   t_d;
  logic [DIV_BITS-1:0]   x_ext;
  logic [SCALE_BITS-1:0] f_xs_q;
  logic                  f_dbz_q;

  logic                  done_q;
  dfpa_out_t             result_q;
  logic [DIV_BITS-1:0]   wrap_ext;

  assign busy_o = 1'b0;

  always_comb begin
    xs_d = (item_i.left_scale > SCALE_BITS'(MAX_SCALE)) ? SCALE_BITS'(MAX_SCALE)
                                                        : item_i.left_scale;
    ys_d = (item_i.right_scale > SCALE_BITS'(MAX_SCALE)) ? SCALE_BITS'(MAX_SCALE)
                                                         : item_i.right_scale;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      m_valid_q  <= 1'b0;
      f_valid_q  <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      s0_valid_q <= start_i && !busy_o;
      s1_valid_q <= s0_valid_q;
      s2_valid_q <= s1_valid_q;
      m_valid_q  <= d1_valid;
      f_valid_q  <= d2_valid;
      done_q     <= f_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_mode_q <= dfpa_mode_e'(item_i.mode);
    s0_xneg_q <= item_i.left_value[OPND_BITS-1];
    s0_yneg_q <= item_i.right_value[OPND_BITS-1];
    s0_xraw_q <= item_i.left_value;
    s0_xmag_q <= item_i.left_value[OPND_BITS-1] ? OPND_BITS'(-item_i.left_value)
                                                : item_i.left_value;
    s0_ymag_q <= item_i.right_value[OPND_BITS-1] ? OPND_BITS'(-item_i.right_value)
                                                 : item_i.right_value;
    s0_pxs_q  <= pow10(xs_d);
    s0_pys_q  <= pow10(ys_d);
    s0_xs_q   <= xs_d;
  end

  // first product is x*y for multiply, y*10^xs otherwise; second is x*10^xs
  always_comb begin
    a1 = (s0_mode_q == MODE_MUL) ? s0_xmag_q : s0_ymag_q;
    b1 = (s0_mode_q == MODE_MUL) ? s0_ymag_q : s0_pxs_q;
  end

  always_ff @(posedge clk_i) begin
    s1_mode_q <= s0_mode_q;
    s1_xneg_q <= s0_xneg_q;
    s1_yneg_q <= s0_yneg_q;
    s1_xraw_q <= s0_xraw_q;
    s1_pys_q  <= s0_pys_q;
    s1_xs_q   <= s0_xs_q;
    pa_q[0]   <= a1[HALF_BITS-1:0] * b1[HALF_BITS-1:0];
    pa_q[1]   <= a1[HALF_BITS-1:0] * b1[OPND_BITS-1:HALF_BITS];
    pa_q[2]   <= a1[OPND_BITS-1:HALF_BITS] * b1[HALF_BITS-1:0];
    pa_q[3]   <= a1[OPND_BITS-1:HALF_BITS] * b1[OPND_BITS-1:HALF_BITS];
    pb_q[0]   <= s0_xmag_q[HALF_BITS-1:0] * s0_pxs_q[HALF_BITS-1:0];
    pb_q[1]   <= s0_xmag_q[HALF_BITS-1:0] * s0_pxs_q[OPND_BITS-1:HALF_BITS];
    pb_q[2]   <= s0_xmag_q[OPND_BITS-1:HALF_BITS] * s0_pxs_q[HALF_BITS-1:0];
    pb_q[3]   <= s0_xmag_q[OPND_BITS-1:HALF_BITS] * s0_pxs_q[OPND_BITS-1:HALF_BITS];
  end

  always_comb begin
    p1_d = {{OPND_BITS{1'b0}}, pa_q[0]}
         + ({{OPND_BITS{1'b0}}, pa_q[1]} << HALF_BITS)
         + ({{OPND_BITS{1'b0}}, pa_q[2]} << HALF_BITS)
         + {pa_q[3], {OPND_BITS{1'b0}}};
    p2_d = {{OPND_BITS{1'b0}}, pb_q[0]}
         + ({{OPND_BITS{1'b0}}, pb_q[1]} << HALF_BITS)
         + ({{OPND_BITS{1'b0}}, pb_q[2]} << HALF_BITS)
         + {pb_q[3], {OPND_BITS{1'b0}}};
  end

  always_ff @(posedge clk_i) begin
    s2_op_q.rem        <= '0;
    s2_op_q.nq         <= p1_d;
    s2_op_q.d          <= {{OPND_BITS{1'b0}}, s1_pys_q};
    s2_op_q.side.mode  <= s1_mode_q;
    s2_op_q.side.x_neg <= s1_xneg_q;
    s2_op_q.side.y_neg <= s1_yneg_q;
    s2_op_q.side.x_raw <= s1_xraw_q;
    s2_op_q.side.scale <= s1_xs_q;
    s2_op_q.side.num2  <= p2_d;
    s2_op_q.side.dbz   <= 1'b0;
  end

  dfpa_div_chain u_div_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid_q),
    .op_i    (s2_op_q),
    .valid_o (d1_valid),
    .op_o    (d1_op)
  );

  // divide mode divides x*10^xs by the rescaled divisor, other modes pass through
  assign q1_zero = d1_op.nq == '0;

  always_comb begin
    m_op_d     = d1_op;
    m_op_d.rem = '0;
    if (d1_op.side.mode == MODE_DIV) begin
      m_op_d.nq       = q1_zero ? '0 : d1_op.side.num2;
      m_op_d.d        = q1_zero ? DIV_BITS'(1) : d1_op.nq;
      m_op_d.side.dbz = q1_zero;
    end else begin
      m_op_d.nq       = d1_op.nq;
      m_op_d.d        = DIV_BITS'(1);
      m_op_d.side.dbz = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    m_op_q <= m_op_d;
  end

  dfpa_div_chain u_div_quot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (m_valid_q),
    .op_i    (m_op_q),
    .valid_o (d2_valid),
    .op_o    (d2_op)
  );

  always_comb begin
    x_ext = {{OPND_BITS{d2_op.side.x_raw[OPND_BITS-1]}}, d2_op.side.x_raw};
    unique case (d2_op.side.mode)
      MODE_ADD: t_d = d2_op.side.y_neg ? x_ext - d2_op.nq : x_ext + d2_op.nq;
      MODE_SUB: t_d = d2_op.side.y_neg ? x_ext + d2_op.nq : x_ext - d2_op.nq;
      default: begin
        if (d2_op.side.dbz) begin
          t_d = '0;
        end else begin
          t_d = (d2_op.side.x_neg != d2_op.side.y_neg) ? DIV_BITS'(-d2_op.nq) : d2_op.nq;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    f_t_q   <= t_d;
    f_xs_q  <= d2_op.side.scale;
    f_dbz_q <= d2_op.side.dbz;
  end

  // wrap to VALUE_BITS signed bits, overflow when that changes the value
  assign wrap_ext = {{(DIV_BITS-VALUE_BITS){f_t_q[VALUE_BITS-1]}}, f_t_q[VALUE_BITS-1:0]};

  always_ff @(posedge clk_i) begin
    result_q.result_value   <= wrap_ext[OPND_BITS-1:0];
    result_q.result_scale   <= f_xs_q;
    result_q.divide_by_zero <= f_dbz_q;
    result_q.overflow       <= wrap_ext != f_t_q;
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule
